// ----- hdl/tvcp_pkg.sv -----
// shared types and character constants for the tag/value command parser
package tvcp_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned DirW   = 3;
  localparam int unsigned SpeedW = 7;

  localparam logic [ByteW-1:0] ChLbrace = 8'h7B;
  localparam logic [ByteW-1:0] ChV      = 8'h56;
  localparam logic [ByteW-1:0] ChEquals = 8'h3D;
  localparam logic [ByteW-1:0] ChComma  = 8'h2C;
  localparam logic [ByteW-1:0] ChPlus   = 8'h2B;
  localparam logic [ByteW-1:0] ChMinus  = 8'h2D;
  localparam logic [ByteW-1:0] ChSpace  = 8'h20;
  localparam logic [ByteW-1:0] ChTab    = 8'h09;
  localparam logic [ByteW-1:0] ChCr     = 8'h0D;
  localparam logic [ByteW-1:0] ChZero   = 8'h30;
  localparam logic [ByteW-1:0] ChNine   = 8'h39;

  localparam logic [ByteW-1:0] ChanDirection = 8'd4;
  localparam logic [ByteW-1:0] ChanSpeed     = 8'd5;

  localparam logic [ByteW-1:0]  DirMax   = 8'd4;
  localparam logic [ByteW-1:0]  SpeedMax = 8'd100;
  localparam logic [ByteW-1:0]  AccMax   = 8'd255;

  localparam logic ChangedDirection = 1'b0;
  localparam logic ChangedSpeed     = 1'b1;

  typedef enum logic [7:0] {
    PH_IDLE    = 8'b0000_0001,
    PH_TAG     = 8'b0000_0010,
    PH_CHANNEL = 8'b0000_0100,
    PH_EQUALS  = 8'b0000_1000,
    PH_LEAD    = 8'b0001_0000,
    PH_SIGNED  = 8'b0010_0000,
    PH_DIGITS  = 8'b0100_0000,
    PH_SKIP    = 8'b1000_0000
  } phase_e;

  typedef struct packed {
    logic             valid;
    logic [ByteW-1:0] char_byte;
    logic             message_end;
  } in_item_t;

  typedef struct packed {
    logic              valid;
    logic [DirW-1:0]   direction;
    logic [SpeedW-1:0] speed;
    logic              changed_item;
  } result_t;

endpackage

// ----- hdl/tvcp_step.sv -----
// parse state and per-byte update logic of the command parser
module tvcp_step (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tvcp_pkg::in_item_t item_i,
  output tvcp_pkg::result_t  result_o
);

  tvcp_pkg::phase_e                phase_q, phase_d, phase_nx;
  logic [tvcp_pkg::ByteW-1:0]      chan_q, chan_d, chan_nx;
  logic [tvcp_pkg::ByteW-1:0]      acc_q, acc_d, acc_nx;
  logic                            neg_q, neg_d, neg_nx;
  logic [tvcp_pkg::DirW-1:0]       dir_q, dir_d, dir_new;
  logic [tvcp_pkg::SpeedW-1:0]     speed_q, speed_d, speed_new;

  logic [tvcp_pkg::ByteW-1:0] b;
  logic                       is_digit, is_space, is_comma;
  logic [11:0]                acc_mul;
  logic [tvcp_pkg::ByteW-1:0] acc_sat;
  logic                       apply_now, neg_eff, is_dir, is_spd;

  assign b        = item_i.char_byte;
  assign is_digit = (b >= tvcp_pkg::ChZero) && (b <= tvcp_pkg::ChNine);
  assign is_space = (b == tvcp_pkg::ChSpace) ||
                    ((b >= tvcp_pkg::ChTab) && (b <= tvcp_pkg::ChCr));
  assign is_comma = (b == tvcp_pkg::ChComma);

  // saturating acc * 10 + digit
  assign acc_mul = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0}
                 + {4'b0000, b - tvcp_pkg::ChZero};
  assign acc_sat = (acc_mul > {4'b0000, tvcp_pkg::AccMax}) ? tvcp_pkg::AccMax
                                                             : acc_mul[7:0];

  always_comb begin
    phase_nx  = phase_q;
    chan_nx   = chan_q;
    acc_nx    = acc_q;
    neg_nx    = neg_q;
    apply_now = 1'b0;
    case (phase_q)
      tvcp_pkg::PH_IDLE: begin
        if (b == tvcp_pkg::ChLbrace) phase_nx = tvcp_pkg::PH_TAG;
      end
      tvcp_pkg::PH_TAG: begin
        if (b == tvcp_pkg::ChV) begin
          phase_nx = tvcp_pkg::PH_CHANNEL;
        end else if (!is_comma) begin
          phase_nx = tvcp_pkg::PH_SKIP;
          neg_nx   = 1'b0;
        end
      end
      tvcp_pkg::PH_CHANNEL: begin
        chan_nx  = b - tvcp_pkg::ChZero;
        phase_nx = tvcp_pkg::PH_EQUALS;
        if (b == tvcp_pkg::ChEquals) begin
          phase_nx = tvcp_pkg::PH_LEAD;
          acc_nx   = '0;
          neg_nx   = 1'b0;
        end
      end
      tvcp_pkg::PH_EQUALS: begin
        if (b == tvcp_pkg::ChEquals) begin
          phase_nx = tvcp_pkg::PH_LEAD;
          acc_nx   = '0;
          neg_nx   = 1'b0;
        end
      end
      tvcp_pkg::PH_LEAD: begin
        if (is_space) begin
          phase_nx = tvcp_pkg::PH_LEAD;
        end else if ((b == tvcp_pkg::ChPlus) || (b == tvcp_pkg::ChMinus)) begin
          neg_nx   = (b == tvcp_pkg::ChMinus);
          phase_nx = tvcp_pkg::PH_SIGNED;
        end else if (is_digit) begin
          acc_nx   = acc_sat;
          phase_nx = tvcp_pkg::PH_DIGITS;
        end else begin
          phase_nx = tvcp_pkg::PH_SKIP;
          neg_nx   = 1'b1;
        end
      end
      tvcp_pkg::PH_SIGNED: begin
        if (is_digit) begin
          acc_nx   = acc_sat;
          phase_nx = tvcp_pkg::PH_DIGITS;
        end else begin
          phase_nx = tvcp_pkg::PH_SKIP;
          neg_nx   = 1'b1;
        end
      end
      tvcp_pkg::PH_DIGITS: begin
        if (is_digit) begin
          acc_nx = acc_sat;
        end else begin
          apply_now = 1'b1;
          neg_nx    = 1'b0;
          phase_nx  = is_comma ? tvcp_pkg::PH_TAG : tvcp_pkg::PH_SKIP;
        end
      end
      tvcp_pkg::PH_SKIP: begin
        if (!neg_q && is_comma) phase_nx = tvcp_pkg::PH_TAG;
      end
      default: begin
        phase_nx = tvcp_pkg::PH_IDLE;
      end
    endcase
    if (item_i.message_end && (phase_nx == tvcp_pkg::PH_DIGITS)) apply_now = 1'b1;
  end

  // apply the finished number to the selected setting
  assign is_dir  = (chan_q == tvcp_pkg::ChanDirection);
  assign is_spd  = (chan_q == tvcp_pkg::ChanSpeed);
  assign neg_eff = neg_q && (acc_nx != '0);
  assign dir_new = (neg_eff || (acc_nx > tvcp_pkg::DirMax)) ? '0
                                                            : acc_nx[tvcp_pkg::DirW-1:0];
  assign speed_new = neg_eff ? '0 :
                     (acc_nx > tvcp_pkg::SpeedMax) ? tvcp_pkg::SpeedMax[tvcp_pkg::SpeedW-1:0]
                                                   : acc_nx[tvcp_pkg::SpeedW-1:0];

  always_comb begin
    phase_d = phase_q;
    chan_d  = chan_q;
    acc_d   = acc_q;
    neg_d   = neg_q;
    dir_d   = dir_q;
    speed_d = speed_q;
    if (item_i.valid) begin
      if (item_i.message_end) begin
        phase_d = tvcp_pkg::PH_IDLE;
        chan_d  = '0;
        acc_d   = '0;
        neg_d   = 1'b0;
      end else begin
        phase_d = phase_nx;
        chan_d  = chan_nx;
        acc_d   = acc_nx;
        neg_d   = neg_nx;
      end
      if (apply_now && is_dir) dir_d   = dir_new;
      if (apply_now && is_spd) speed_d = speed_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= tvcp_pkg::PH_IDLE;
      chan_q  <= '0;
      acc_q   <= '0;
      neg_q   <= 1'b0;
      dir_q   <= '0;
      speed_q <= '0;
    end else begin
      phase_q <= phase_d;
      chan_q  <= chan_d;
      acc_q   <= acc_d;
      neg_q   <= neg_d;
      dir_q   <= dir_d;
      speed_q <= speed_d;
    end
  end

  assign result_o.valid        = item_i.valid && apply_now && (is_dir || is_spd);
  assign result_o.direction    = dir_d;
  assign result_o.speed        = speed_d;
  assign result_o.changed_item = is_spd ? tvcp_pkg::ChangedSpeed
                                        : tvcp_pkg::ChangedDirection;

endmodule

// ----- hdl/tag_value_command_parser_core.sv -----
// top level of the tag/value command parser: input register, parser, result register
// Parses {Vc=n,...} command text one byte per item at one item per clock unless the
// output stalls; an item waits in the input register until the result register can
// advance, then its result (if any) is loaded into the result register. Channel 4
// sets direction, channel 5 speed; an item produces a result only when it finishes a
// number for one of those channels. The input side stalls only while both the input
// register and result register hold items and downstream is not taking the result.
module tag_value_command_parser_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [tvcp_pkg::ByteW-1:0]    char_byte_i,
  input  logic                          message_end_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [tvcp_pkg::DirW-1:0]     direction_o,
  output logic [tvcp_pkg::SpeedW-1:0]   speed_o,
  output logic                          changed_item_o
);

  logic                       in_valid_q, in_valid_d;
  logic [tvcp_pkg::ByteW-1:0] in_byte_q;
  logic                       in_end_q;
  logic                       advance, fire, in_take;
  tvcp_pkg::in_item_t         step_item;
  tvcp_pkg::result_t          step_res;
  tvcp_pkg::result_t          out_q, out_d;

  assign advance    = !out_q.valid || out_ready_i;
  assign fire       = in_valid_q && advance;
  assign in_ready_o = !in_valid_q || advance;
  assign in_take    = in_valid_i && in_ready_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_take)   in_valid_d = 1'b1;
    else if (fire) in_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q <= char_byte_i;
      in_end_q  <= message_end_i;
    end
  end

  assign step_item.valid       = fire;
  assign step_item.char_byte   = in_byte_q;
  assign step_item.message_end = in_end_q;

  tvcp_step u_step (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (step_item),
    .result_o (step_res)
  );

  always_comb begin
    out_d = out_q;
    if (fire) begin
      out_d = step_res;
    end else if (out_ready_i) begin
      out_d.valid = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_q <= '0;
    end else begin
      out_q <= out_d;
    end
  end

  assign out_valid_o    = out_q.valid;
  assign direction_o    = out_q.direction;
  assign speed_o        = out_q.speed;
  assign changed_item_o = out_q.changed_item;

  a_dir_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (direction_o <= tvcp_pkg::DirMax[tvcp_pkg::DirW-1:0]))
    else $error("direction out of range");

  a_speed_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (speed_o <= tvcp_pkg::SpeedMax[tvcp_pkg::SpeedW-1:0]))
    else $error("speed out of range");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (in_valid_q && out_valid_o && !out_ready_i))
    else $error("input stalled without a blocked result");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(fire))
    else $error("result appeared without a parsed item");

endmodule

// ----- tb/sv/tb_tag_value_command_parser_core.sv -----
// testbench for tag_value_command_parser_core: random command text checked against a parser model
`timescale 1ns / 100ps

module tb_tag_value_command_parser_core;

  localparam int unsigned HoldCycles    = 400;
  localparam int unsigned WatchdogLimit = 5000;
  localparam int unsigned ItemsPerPhase = 180;

  localparam logic [tvcp_pkg::ByteW-1:0] ChRbrace = 8'h7D;
  localparam logic [tvcp_pkg::ByteW-1:0] ChLowerA = 8'h61;

  typedef struct {
    logic [tvcp_pkg::ByteW-1:0] char_byte;
    logic                       message_end;
  } cmd_byte_t;

  typedef struct {
    logic [tvcp_pkg::DirW-1:0]   direction;
    logic [tvcp_pkg::SpeedW-1:0] speed;
    logic                        changed_item;
  } setting_t;

  logic                        clk_i;
  logic                        rst_ni;
  logic                        in_valid;
  logic                        in_ready_o;
  logic [tvcp_pkg::ByteW-1:0]  char_d;
  logic                        msg_end_d;
  logic                        out_valid_o;
  logic                        out_ready;
  logic [tvcp_pkg::DirW-1:0]   direction_o;
  logic [tvcp_pkg::SpeedW-1:0] speed_o;
  logic                        changed_item_o;

  cmd_byte_t                  cmd_bytes_q[$];
  logic [tvcp_pkg::ByteW-1:0] msg_buf[$];
  setting_t                   expected_settings_q[$];

  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  int unsigned hold_req      = 0;
  int unsigned hold_ack;
  int unsigned hold_left;
  int unsigned idle_cycles;
  int unsigned gen_count     = 0;
  int unsigned mismatch_cnt  = 0;
  int unsigned fail_cnt      = 0;

  // parser model state
  tvcp_pkg::phase_e            ph    = tvcp_pkg::PH_IDLE;
  logic [tvcp_pkg::ByteW-1:0]  chan  = '0;
  logic [tvcp_pkg::ByteW-1:0]  acc   = '0;
  logic                        neg   = 1'b0;
  logic [tvcp_pkg::DirW-1:0]   dir_q = '0;
  logic [tvcp_pkg::SpeedW-1:0] spd_q = '0;

  cmd_byte_t nxt_byte;
  setting_t  exp_s;

  int unsigned send_pcts[4]  = '{0, 84, 0, 21};
  int unsigned stall_pcts[4] = '{0, 0, 84, 21};

  tag_value_command_parser_core u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready_o),
    .char_byte_i    (char_d),
    .message_end_i  (msg_end_d),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready),
    .direction_o    (direction_o),
    .speed_o        (speed_o),
    .changed_item_o (changed_item_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [tvcp_pkg::ByteW-1:0] saturating_digit(
      input logic [tvcp_pkg::ByteW-1:0] a,
      input logic [tvcp_pkg::ByteW-1:0] b);
    int v;
    v = int'(a) * 10 + (int'(b) - int'(tvcp_pkg::ChZero));
    return (v > 255) ? tvcp_pkg::AccMax : v[tvcp_pkg::ByteW-1:0];
  endfunction

  task automatic apply_number();
    logic [tvcp_pkg::ByteW-1:0] mag;
    logic                       negv;
    mag  = acc;
    negv = neg && (mag != 0);
    if (chan == tvcp_pkg::ChanDirection) begin
      dir_q = (negv || mag > tvcp_pkg::DirMax) ? '0 : mag[tvcp_pkg::DirW-1:0];
      expected_settings_q.push_back('{dir_q, spd_q, tvcp_pkg::ChangedDirection});
    end else if (chan == tvcp_pkg::ChanSpeed) begin
      spd_q = negv ? '0 : ((mag > tvcp_pkg::SpeedMax) ?
                           tvcp_pkg::SpeedMax[tvcp_pkg::SpeedW-1:0] :
                           mag[tvcp_pkg::SpeedW-1:0]);
      expected_settings_q.push_back('{dir_q, spd_q, tvcp_pkg::ChangedSpeed});
    end
  endtask

  task automatic parse_byte(input logic [tvcp_pkg::ByteW-1:0] b, input logic last);
    logic dig;
    logic blank;
    dig   = (b >= tvcp_pkg::ChZero) && (b <= tvcp_pkg::ChNine);
    blank = (b == tvcp_pkg::ChSpace) || ((b >= tvcp_pkg::ChTab) && (b <= tvcp_pkg::ChCr));
    case (ph)
      tvcp_pkg::PH_IDLE: begin
        if (b == tvcp_pkg::ChLbrace) ph = tvcp_pkg::PH_TAG;
      end
      tvcp_pkg::PH_TAG: begin
        if (b == tvcp_pkg::ChV) ph = tvcp_pkg::PH_CHANNEL;
        else if (b != tvcp_pkg::ChComma) begin
          ph  = tvcp_pkg::PH_SKIP;
          neg = 1'b0;
        end
      end
      tvcp_pkg::PH_CHANNEL: begin
        chan = b - tvcp_pkg::ChZero;
        ph   = tvcp_pkg::PH_EQUALS;
        if (b == tvcp_pkg::ChEquals) begin
          ph  = tvcp_pkg::PH_LEAD;
          acc = '0;
          neg = 1'b0;
        end
      end
      tvcp_pkg::PH_EQUALS: begin
        if (b == tvcp_pkg::ChEquals) begin
          ph  = tvcp_pkg::PH_LEAD;
          acc = '0;
          neg = 1'b0;
        end
      end
      tvcp_pkg::PH_LEAD: begin
        if (!blank) begin
          if (b == tvcp_pkg::ChPlus || b == tvcp_pkg::ChMinus) begin
            neg = (b == tvcp_pkg::ChMinus);
            ph  = tvcp_pkg::PH_SIGNED;
          end else if (dig) begin
            acc = saturating_digit(acc, b);
            ph  = tvcp_pkg::PH_DIGITS;
          end else begin
            ph  = tvcp_pkg::PH_SKIP;
            neg = 1'b1;
          end
        end
      end
      tvcp_pkg::PH_SIGNED: begin
        if (dig) begin
          acc = saturating_digit(acc, b);
          ph  = tvcp_pkg::PH_DIGITS;
        end else begin
          ph  = tvcp_pkg::PH_SKIP;
          neg = 1'b1;
        end
      end
      tvcp_pkg::PH_DIGITS: begin
        if (dig) acc = saturating_digit(acc, b);
        else begin
          apply_number();
          neg = 1'b0;
          ph  = (b == tvcp_pkg::ChComma) ? tvcp_pkg::PH_TAG : tvcp_pkg::PH_SKIP;
        end
      end
      default: begin
        if (!neg && b == tvcp_pkg::ChComma) ph = tvcp_pkg::PH_TAG;
      end
    endcase
    if (last) begin
      if (ph == tvcp_pkg::PH_DIGITS) apply_number();
      ph   = tvcp_pkg::PH_IDLE;
      chan = '0;
      acc  = '0;
      neg  = 1'b0;
    end
  endtask

  // message assembly
  task automatic add_str(input string s);
    for (int i = 0; i < s.len(); i++) msg_buf.push_back(s[i]);
  endtask

  task automatic flush_message(input bit end_last);
    for (int i = 0; i < msg_buf.size(); i++) begin
      cmd_bytes_q.push_back('{msg_buf[i], end_last && (i == msg_buf.size() - 1)});
    end
    gen_count += msg_buf.size();
    msg_buf.delete();
  endtask

  task automatic gen_message(input bit rich);
    int unsigned nf;
    int unsigned r;
    int unsigned cut;
    bit          eq_done;
    msg_buf.delete();
    if (!rich && $urandom_range(99) < 10) begin
      repeat ($urandom_range(1, 8)) msg_buf.push_back(8'($urandom_range(255)));
      flush_message($urandom_range(1) == 1);
      return;
    end
    if (!rich && $urandom_range(19) == 0) msg_buf.push_back(8'($urandom_range(255)));
    msg_buf.push_back(tvcp_pkg::ChLbrace);
    nf = rich ? $urandom_range(3, 6) : $urandom_range(1, 4);
    for (int f = 0; f < nf; f++) begin
      eq_done = 1'b0;
      if (!rich && $urandom_range(24) == 0) msg_buf.push_back(8'($urandom_range(255)));
      msg_buf.push_back(tvcp_pkg::ChV);
      r = $urandom_range(99);
      if (rich || r < 75) begin
        msg_buf.push_back(tvcp_pkg::ChZero + ($urandom_range(1) ? tvcp_pkg::ChanDirection
                                                                : tvcp_pkg::ChanSpeed));
      end else if (r < 85) begin
        msg_buf.push_back(tvcp_pkg::ChEquals);
        eq_done = 1'b1;
      end else begin
        msg_buf.push_back(8'($urandom_range(255)));
      end
      if (!eq_done) begin
        if (!rich && $urandom_range(9) == 0) msg_buf.push_back(8'($urandom_range(255)));
        msg_buf.push_back(tvcp_pkg::ChEquals);
      end
      if ($urandom_range(4) == 0) begin
        repeat ($urandom_range(1, 2)) begin
          r = $urandom_range(5);
          msg_buf.push_back((r == 0) ? tvcp_pkg::ChSpace : tvcp_pkg::ChTab + 8'(r - 1));
        end
      end
      r = $urandom_range(9);
      if (r == 0) msg_buf.push_back(tvcp_pkg::ChPlus);
      else if (r == 1) msg_buf.push_back(tvcp_pkg::ChMinus);
      if (!rich && $urandom_range(19) == 0)
        msg_buf.push_back(ChLowerA + 8'($urandom_range(25)));
      if (rich || $urandom_range(1))
        msg_buf.push_back(tvcp_pkg::ChZero + 8'($urandom_range(9)));
      else repeat ($urandom_range(1, 4))
        msg_buf.push_back(tvcp_pkg::ChZero + 8'($urandom_range(9)));
      if (f != nf - 1) begin
        if (!rich && $urandom_range(9) == 0)
          msg_buf.push_back(ChLowerA + 8'($urandom_range(25)));
        msg_buf.push_back(tvcp_pkg::ChComma);
      end
    end
    r = $urandom_range(99);
    if (rich || r < 65) msg_buf.push_back(ChRbrace);
    else if (r >= 90) begin
      cut = $urandom_range(1, msg_buf.size() - 1);
      repeat (cut) void'(msg_buf.pop_back());
    end
    flush_message(1'b1);
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (cmd_bytes_q.size() != 0 || in_valid || expected_settings_q.size() != 0);
  endtask

  // sender
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid  <= 1'b0;
      char_d    <= '0;
      msg_end_d <= 1'b0;
    end else begin
      if (in_valid && in_ready_o) parse_byte(char_d, msg_end_d);
      if (!in_valid || in_ready_o) begin
        if (cmd_bytes_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt_byte  = cmd_bytes_q.pop_front();
          in_valid  <= 1'b1;
          char_d    <= nxt_byte.char_byte;
          msg_end_d <= nxt_byte.message_end;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
      hold_ack  <= 0;
      hold_left <= 0;
    end else if (hold_ack != hold_req) begin
      hold_ack  <= hold_req;
      hold_left <= HoldCycles;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // result check
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready) begin
      if (expected_settings_q.size() == 0) begin
        fail_cnt++;
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("unexpected result: dir %0d speed %0d changed %0d",
                   direction_o, speed_o, changed_item_o);
      end else begin
        exp_s = expected_settings_q.pop_front();
        if (direction_o !== exp_s.direction || speed_o !== exp_s.speed ||
            changed_item_o !== exp_s.changed_item) begin
          fail_cnt++;
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display({"mismatch: exp dir %0d speed %0d changed %0d, ",
                      "got dir %0d speed %0d changed %0d"},
                     exp_s.direction, exp_s.speed, exp_s.changed_item,
                     direction_o, speed_o, changed_item_o);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_cycles <= 0;
    end else if ((in_valid && in_ready_o) || (out_valid_o && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_ni = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: byte extremes, sign, tab, range limits, bare '=' channel, stray brace,
    // saturation and end on a digit
    msg_buf.push_back(8'h00);
    msg_buf.push_back(8'hFF);
    flush_message(1'b0);
    add_str("{V4=\t+3,V5=-7q,V=2,{,V5=999");
    flush_message(1'b1);
    wait_drained();

    for (int p = 0; p < 4; p++) begin
      send_idle_pct = send_pcts[p];
      stall_pct     = stall_pcts[p];
      gen_count     = 0;
      while (gen_count < ItemsPerPhase) gen_message(1'b0);
      wait_drained();
    end

    // long receiver hold while the sender keeps offering result-heavy messages
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_req      = hold_req + 1;
    gen_count     = 0;
    while (gen_count < 100) gen_message(1'b1);
    wait_drained();

    repeat (10) @(negedge clk_i);
    if (fail_cnt == 0 && expected_settings_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/tvcp_pkg.sv
hdl/tvcp_step.sv
hdl/tag_value_command_parser_core.sv
tb/sv/tb_tag_value_command_parser_core.sv
